>>> src/pbnm_pkg.sv
// Package with the shared constants, command codes and transaction types of the palette blend block.
`timescale 1ns / 1ps
`default_nettype none
package pbnm_pkg;

   localparam int PALETTE_ENTRIES = 256;
   localparam int PAL_AW          = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
   localparam int COLOR_W         = 8;
   localparam int INDEX_W         = 8;
   localparam int ALPHA_W         = 9;
   localparam int CACHE_AW        = 2 * INDEX_W;
   localparam int CACHE_DEPTH     = 1 << CACHE_AW;
   localparam int EPOCH_W         = 8;
   localparam int SQ_W            = 2 * COLOR_W;
   localparam int DIST_W          = SQ_W + 2;

   localparam logic [ALPHA_W-1:0] ALPHA_RESET = 9'd128;
   localparam logic [ALPHA_W-1:0] ALPHA_FULL  = 9'd256;

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_CLEAR = 2'd1,
      CMD_MATCH = 2'd2,
      CMD_BLEND = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type            cmd;
      logic [INDEX_W-1:0] entry_index;
      logic [INDEX_W-1:0] src_color;
      logic [INDEX_W-1:0] dst_color;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] match_index;
      logic               from_cache;
   } rsp_type;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } rgb_type;

   typedef struct packed {
      logic               en;
      logic [INDEX_W-1:0] addr;
   } pal_rd_type;

   typedef struct packed {
      logic               en;
      logic [INDEX_W-1:0] addr;
      rgb_type            rgb;
   } pal_wr_type;

   typedef struct packed {
      logic                lookup;
      logic                write;
      logic                clear;
      logic [CACHE_AW-1:0] addr;
      logic [INDEX_W-1:0]  index;
   } cache_req_type;

   typedef struct packed {
      logic               hit;
      logic [INDEX_W-1:0] index;
      logic               busy;
   } cache_rsp_type;

   typedef struct packed {
      logic               done;
      logic               busy;
      logic [INDEX_W-1:0] index;
   } match_rsp_type;

endpackage
`default_nettype wire

>>> src/pbnm_pal_mem.sv
// Palette memory with one write port, one registered read port and per-entry valid flags.
`timescale 1ns / 1ps
`default_nettype none
module pbnm_pal_mem (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire pbnm_pkg::pal_wr_type wr,
   input  wire pbnm_pkg::pal_rd_type rd,
   output pbnm_pkg::rgb_type         rd_rgb
);

   pbnm_pkg::rgb_type                       mem [pbnm_pkg::PALETTE_ENTRIES];
   logic [pbnm_pkg::PALETTE_ENTRIES-1:0]    valid_ff;
   pbnm_pkg::rgb_type                       data_ff;
   logic                                    ok_ff;
   logic                                    wr_in_range;
   logic                                    rd_in_range;
   logic [pbnm_pkg::PAL_AW-1:0]             wr_idx;
   logic [pbnm_pkg::PAL_AW-1:0]             rd_idx;

   always_comb begin
      wr_in_range = {1'b0, wr.addr} < (pbnm_pkg::INDEX_W + 1)'(pbnm_pkg::PALETTE_ENTRIES);
      rd_in_range = {1'b0, rd.addr} < (pbnm_pkg::INDEX_W + 1)'(pbnm_pkg::PALETTE_ENTRIES);
      wr_idx      = wr.addr[pbnm_pkg::PAL_AW-1:0];
      rd_idx      = rd.addr[pbnm_pkg::PAL_AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (wr.en && wr_in_range) begin
         mem[wr_idx] <= wr.rgb;
      end
      if (rd.en) begin
         data_ff <= mem[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         ok_ff    <= 1'b0;
      end else begin
         if (wr.en && wr_in_range) begin
            valid_ff[wr_idx] <= 1'b1;
         end
         if (rd.en) begin
            ok_ff <= rd_in_range && valid_ff[rd_idx];
         end
      end
   end

   assign rd_rgb = ok_ff ? data_ff : '0;

endmodule
`default_nettype wire

>>> src/pbnm_cache_mem.sv
// Blend cache memory with epoch tags for fast clears and a sweep after reset and epoch wrap.
`timescale 1ns / 1ps
`default_nettype none
module pbnm_cache_mem (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire pbnm_pkg::cache_req_type req,
   output pbnm_pkg::cache_rsp_type      rsp
);

   localparam int ENTRY_W = pbnm_pkg::EPOCH_W + pbnm_pkg::INDEX_W;

   logic [ENTRY_W-1:0]            mem [pbnm_pkg::CACHE_DEPTH];
   logic [ENTRY_W-1:0]            rd_ff;
   logic                          sweep_ff;
   logic [pbnm_pkg::CACHE_AW-1:0] sweep_addr_ff;
   logic [pbnm_pkg::EPOCH_W-1:0]  epoch_ff;
   logic                          we;
   logic [pbnm_pkg::CACHE_AW-1:0] waddr;
   logic [ENTRY_W-1:0]            wdata;

   always_comb begin
      if (sweep_ff) begin
         we    = 1'b1;
         waddr = sweep_addr_ff;
         wdata = '0;
      end else begin
         we    = req.write;
         waddr = req.addr;
         wdata = {epoch_ff, req.index};
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (req.lookup) begin
         rd_ff <= mem[req.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff      <= 1'b1;
         sweep_addr_ff <= '0;
         epoch_ff      <= '0;
      end else if (sweep_ff) begin
         sweep_addr_ff <= sweep_addr_ff + 1'b1;
         if (&sweep_addr_ff) begin
            sweep_ff <= 1'b0;
            epoch_ff <= pbnm_pkg::EPOCH_W'(1);
         end
      end else if (req.clear) begin
         if (&epoch_ff) begin
            sweep_ff      <= 1'b1;
            sweep_addr_ff <= '0;
         end else begin
            epoch_ff <= epoch_ff + 1'b1;
         end
      end
   end

   always_comb begin
      rsp.hit   = rd_ff[ENTRY_W-1:pbnm_pkg::INDEX_W] == epoch_ff;
      rsp.index = rd_ff[pbnm_pkg::INDEX_W-1:0];
      rsp.busy  = sweep_ff;
   end

endmodule
`default_nettype wire

>>> src/pbnm_match.sv
// Nearest color search that scans the palette one entry per cycle through a three-stage pipeline.
`timescale 1ns / 1ps
`default_nettype none
module pbnm_match (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire pbnm_pkg::rgb_type target,
   input  wire pbnm_pkg::rgb_type pal_rgb,
   output pbnm_pkg::pal_rd_type   pal_rd,
   output pbnm_pkg::match_rsp_type rsp
);

   localparam logic [pbnm_pkg::PAL_AW-1:0] LAST_ADDR =
      pbnm_pkg::PAL_AW'(pbnm_pkg::PALETTE_ENTRIES - 1);

   logic                          run_ff;
   logic [pbnm_pkg::PAL_AW-1:0]   addr_ff;
   logic                          v1_ff;
   logic                          last1_ff;
   logic [pbnm_pkg::PAL_AW-1:0]   idx1_ff;
   logic                          v2_ff;
   logic                          last2_ff;
   logic [pbnm_pkg::PAL_AW-1:0]   idx2_ff;
   logic [pbnm_pkg::SQ_W-1:0]     sq_r_ff;
   logic [pbnm_pkg::SQ_W-1:0]     sq_g_ff;
   logic [pbnm_pkg::SQ_W-1:0]     sq_b_ff;
   logic [pbnm_pkg::DIST_W-1:0]   best_err_ff;
   logic [pbnm_pkg::PAL_AW-1:0]   best_idx_ff;
   logic                          done_ff;
   logic [pbnm_pkg::SQ_W-1:0]     sq_r_in;
   logic [pbnm_pkg::SQ_W-1:0]     sq_g_in;
   logic [pbnm_pkg::SQ_W-1:0]     sq_b_in;
   logic [pbnm_pkg::DIST_W-1:0]   err;

   function automatic logic [pbnm_pkg::SQ_W-1:0] square_diff(
      input logic [pbnm_pkg::COLOR_W-1:0] a,
      input logic [pbnm_pkg::COLOR_W-1:0] b
   );
      logic signed [pbnm_pkg::COLOR_W:0]       d;
      logic signed [2*pbnm_pkg::COLOR_W+1:0]   p;
      d = $signed({1'b0, a}) - $signed({1'b0, b});
      p = d * d;
      return p[pbnm_pkg::SQ_W-1:0];
   endfunction

   always_comb begin
      sq_r_in = square_diff(target.red, pal_rgb.red);
      sq_g_in = square_diff(target.green, pal_rgb.green);
      sq_b_in = square_diff(target.blue, pal_rgb.blue);
      err     = pbnm_pkg::DIST_W'(sq_r_ff) + pbnm_pkg::DIST_W'(sq_g_ff)
              + pbnm_pkg::DIST_W'(sq_b_ff);
   end

   always_ff @(posedge clock) begin
      idx1_ff  <= addr_ff;
      last1_ff <= addr_ff == LAST_ADDR;
      idx2_ff  <= idx1_ff;
      last2_ff <= last1_ff;
      sq_r_ff  <= sq_r_in;
      sq_g_ff  <= sq_g_in;
      sq_b_ff  <= sq_b_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff      <= 1'b0;
         addr_ff     <= '0;
         v1_ff       <= 1'b0;
         v2_ff       <= 1'b0;
         done_ff     <= 1'b0;
         best_err_ff <= '1;
         best_idx_ff <= '0;
      end else begin
         v1_ff   <= run_ff;
         v2_ff   <= v1_ff;
         done_ff <= v2_ff && last2_ff;
         if (start) begin
            run_ff      <= 1'b1;
            addr_ff     <= '0;
            best_err_ff <= '1;
            best_idx_ff <= '0;
         end else begin
            if (run_ff) begin
               addr_ff <= addr_ff + 1'b1;
               if (addr_ff == LAST_ADDR) begin
                  run_ff <= 1'b0;
               end
            end
            if (v2_ff && (err < best_err_ff)) begin
               best_err_ff <= err;
               best_idx_ff <= idx2_ff;
            end
         end
      end
   end

   always_comb begin
      pal_rd.en  = run_ff;
      pal_rd.addr = pbnm_pkg::INDEX_W'(addr_ff);
      rsp.done   = done_ff;
      rsp.busy   = run_ff || v1_ff || v2_ff;
      rsp.index  = pbnm_pkg::INDEX_W'(best_idx_ff);
   end

endmodule
`default_nettype wire

>>> src/palette_blend_nearest_match_top.sv
// Top level of the palette blend block: command sequencer, color mixer and result register.
//
//   Channel  Direction  Handshake       Payload
//   req_     in         valid / stall   pbnm_pkg::req_type
//   rsp_     out        valid / stall   pbnm_pkg::rsp_type
//   csr_     in         valid / ready   alpha_level, 9 bits
//
// A match is paced by the palette scan, which reads one entry per cycle from the single
// palette read port. A blend hit is answered from the cache; a blend miss runs the scan.
// After reset, and after every 255th clear, the cache sweep holds req_stall high while it
// clears every cache entry. The result register lets the next transaction start while
// rsp_ is stalled.
`timescale 1ns / 1ps
`default_nettype none
module palette_blend_nearest_match_top (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire pbnm_pkg::req_type              req_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output pbnm_pkg::rsp_type                   rsp_data,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [pbnm_pkg::ALPHA_W-1:0]   csr_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOK,
      ST_RD_DST,
      ST_RD_SRC,
      ST_SCAN,
      ST_DONE
   } state_type;

   state_type                       state_ff;
   logic [pbnm_pkg::ALPHA_W-1:0]    alpha_ff;
   logic [pbnm_pkg::INDEX_W-1:0]    dst_ff;
   logic [pbnm_pkg::INDEX_W-1:0]    src_ff;
   logic                            blend_ff;
   logic                            start_ff;
   pbnm_pkg::rgb_type               target_ff;
   pbnm_pkg::rgb_type               dst_rgb_ff;
   pbnm_pkg::rsp_type               res_ff;
   pbnm_pkg::rsp_type               out_ff;
   logic                            out_valid_ff;

   logic                            accept;
   logic                            take;
   logic [pbnm_pkg::ALPHA_W-1:0]    alpha_sat;
   pbnm_pkg::rgb_type               mix_in;
   pbnm_pkg::rgb_type               pal_rgb;
   pbnm_pkg::pal_rd_type            top_rd;
   pbnm_pkg::pal_rd_type            match_rd;
   pbnm_pkg::pal_rd_type            pal_rd;
   pbnm_pkg::pal_wr_type            pal_wr;
   pbnm_pkg::cache_req_type         cache_req;
   pbnm_pkg::cache_rsp_type         cache_rsp;
   pbnm_pkg::match_rsp_type         match_rsp;

   function automatic logic [pbnm_pkg::COLOR_W-1:0] mix(
      input logic [pbnm_pkg::COLOR_W-1:0] cd,
      input logic [pbnm_pkg::COLOR_W-1:0] cs,
      input logic [pbnm_pkg::ALPHA_W-1:0] a
   );
      logic signed [pbnm_pkg::COLOR_W:0]                      d;
      logic signed [pbnm_pkg::COLOR_W+pbnm_pkg::ALPHA_W+1:0]  p;
      logic signed [pbnm_pkg::COLOR_W+pbnm_pkg::ALPHA_W+1:0]  s;
      d = $signed({1'b0, cd}) - $signed({1'b0, cs});
      p = d * $signed({1'b0, a});
      s = $signed({3'b000, cs, 8'h00}) + p;
      return s[15:8];
   endfunction

   assign accept    = req_valid && !req_stall;
   assign take      = out_valid_ff && !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || cache_rsp.busy;
   assign csr_ready = 1'b1;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      alpha_sat    = (alpha_ff > pbnm_pkg::ALPHA_FULL) ? pbnm_pkg::ALPHA_FULL : alpha_ff;
      mix_in.red   = mix(dst_rgb_ff.red, pal_rgb.red, alpha_sat);
      mix_in.green = mix(dst_rgb_ff.green, pal_rgb.green, alpha_sat);
      mix_in.blue  = mix(dst_rgb_ff.blue, pal_rgb.blue, alpha_sat);

      top_rd.en   = ((state_ff == ST_LOOK) && !cache_rsp.hit) || (state_ff == ST_RD_DST);
      top_rd.addr = (state_ff == ST_LOOK) ? dst_ff : src_ff;
      pal_rd      = match_rd.en ? match_rd : top_rd;

      pal_wr.en      = accept && (req_data.cmd == pbnm_pkg::CMD_WRITE);
      pal_wr.addr    = req_data.entry_index;
      pal_wr.rgb.red   = req_data.red;
      pal_wr.rgb.green = req_data.green;
      pal_wr.rgb.blue  = req_data.blue;

      cache_req.lookup = accept && (req_data.cmd == pbnm_pkg::CMD_BLEND);
      cache_req.clear  = accept && (req_data.cmd == pbnm_pkg::CMD_CLEAR);
      cache_req.write  = (state_ff == ST_SCAN) && match_rsp.done && blend_ff;
      cache_req.addr   = cache_req.lookup ? {req_data.dst_color, req_data.src_color}
                                          : {dst_ff, src_ff};
      cache_req.index  = match_rsp.index;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= pbnm_pkg::ALPHA_RESET;
      end else if (csr_valid && csr_ready) begin
         alpha_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
         blend_ff     <= 1'b0;
      end else begin
         start_ff <= 1'b0;
         if (take && (state_ff != ST_DONE)) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  dst_ff <= req_data.dst_color;
                  src_ff <= req_data.src_color;
                  case (req_data.cmd)
                     pbnm_pkg::CMD_MATCH: begin
                        blend_ff         <= 1'b0;
                        start_ff         <= 1'b1;
                        target_ff.red    <= req_data.red;
                        target_ff.green  <= req_data.green;
                        target_ff.blue   <= req_data.blue;
                        state_ff         <= ST_SCAN;
                     end
                     pbnm_pkg::CMD_BLEND: begin
                        blend_ff <= 1'b1;
                        state_ff <= ST_LOOK;
                     end
                     default: begin
                        state_ff <= ST_IDLE;
                     end
                  endcase
               end
            end
            ST_LOOK: begin
               if (cache_rsp.hit) begin
                  res_ff.match_index <= cache_rsp.index;
                  res_ff.from_cache  <= 1'b1;
                  state_ff           <= ST_DONE;
               end else begin
                  state_ff <= ST_RD_DST;
               end
            end
            ST_RD_DST: begin
               dst_rgb_ff <= pal_rgb;
               state_ff   <= ST_RD_SRC;
            end
            ST_RD_SRC: begin
               target_ff <= mix_in;
               start_ff  <= 1'b1;
               state_ff  <= ST_SCAN;
            end
            ST_SCAN: begin
               if (match_rsp.done) begin
                  res_ff.match_index <= match_rsp.index;
                  res_ff.from_cache  <= 1'b0;
                  state_ff           <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (!out_valid_ff || !rsp_stall) begin
                  out_ff       <= res_ff;
                  out_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   pbnm_pal_mem u_pal_mem (
      .clock  (clock),
      .reset  (reset),
      .wr     (pal_wr),
      .rd     (pal_rd),
      .rd_rgb (pal_rgb)
   );

   pbnm_cache_mem u_cache_mem (
      .clock (clock),
      .reset (reset),
      .req   (cache_req),
      .rsp   (cache_rsp)
   );

   pbnm_match u_match (
      .clock   (clock),
      .reset   (reset),
      .start   (start_ff),
      .target  (target_ff),
      .pal_rgb (pal_rgb),
      .pal_rd  (match_rd),
      .rsp     (match_rsp)
   );

endmodule
`default_nettype wire
